// ===== hdl/grid_ray_march_height_unit_macros.svh =====
// Assertion macros shared by the grid ray march height unit checkers.
`ifndef GRID_RAY_MARCH_HEIGHT_UNIT_MACROS_SVH
`define GRID_RAY_MARCH_HEIGHT_UNIT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define GRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("grm check failed");

// Next-cycle implication, gated by the active-low reset.
`define GRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("grm check failed");

`endif

// ===== hdl/grm_pkg.sv =====
// Types and constants shared by the grid ray march height unit.
package grm_pkg;

  localparam int SCREEN_COLUMNS = 32;
  localparam logic [7:0] HALF_COLS = 8'(SCREEN_COLUMNS / 2);

  localparam int HW   = 16;
  localparam int IHW  = 15;
  localparam int ANGW = 8;
  localparam int TRIG_DEPTH = 1 << ANGW;

  localparam logic [HW-1:0]  FAR_DELTA       = 16'd10000;
  localparam logic [IHW-1:0] INIT_HEIGHT_RST = 15'd16384;

  localparam int  CFG_AW = 3;
  localparam int  CFG_DW = 32;
  localparam logic CFG_IDX_INIT_HEIGHT = 1'b0;

  typedef enum logic [1:0] {
    FUNC_TRACE   = 2'd0,
    FUNC_TRIG    = 2'd1,
    FUNC_CELL    = 2'd2,
    FUNC_REBUILD = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TRIG,
    S_INIT,
    S_MARCH,
    S_RESULT,
    S_RB_ZERO,
    S_RB_FAR,
    S_RB_DIV,
    S_RB_WAIT
  } state_t;

  typedef struct packed {
    logic trace_latch;
    logic trig_we;
    logic cell_we;
    logic march_init;
    logic march_step;
    logic res_load;
    logic out_load;
    logic clr_step;
    logic rb_init;
    logic rb_wr_zero;
    logic rb_wr_far;
    logic rb_wr_step;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic wall;
    logic too_low;
    logic march_last;
    logic div_done;
    logic rb_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/grm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the distance table rebuild.
module grm_div #(
  parameter int DVW = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [grm_pkg::IHW-1:0] dividend,
  input  logic [DVW-1:0]          divisor,
  output logic                    done,
  output logic [grm_pkg::IHW-1:0] quotient
);
  import grm_pkg::*;

  localparam int CW = $clog2(IHW);

  logic [IHW-1:0] num_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] dv_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [DVW:0]   trial;
  logic           qbit;

  assign trial = {rem_r, num_r[IHW-1]};
  assign qbit  = trial >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(IHW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[IHW-2:0], qbit};
      rem_r <= qbit ? DVW'(trial - {1'b0, dv_r}) : trial[DVW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

// ===== hdl/grm_ctrl.sv =====
// Sequencer for clear, trace, table write and distance table rebuild.
module grm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic [1:0]     in_tuser,
  output logic           in_tready,
  input  grm_pkg::stat_t stat,
  output grm_pkg::cmd_t  cmd
);
  import grm_pkg::*;

  state_t state_r;
  state_t state_nxt;
  func_t  func;
  logic   finish;

  assign func   = func_t'(in_tuser);
  assign finish = stat.wall || stat.too_low || stat.march_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (func)
            FUNC_TRACE:   state_nxt = S_TRIG;
            FUNC_REBUILD: state_nxt = S_RB_ZERO;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_TRIG:    state_nxt = S_INIT;
      S_INIT:    state_nxt = S_MARCH;
      S_MARCH: begin
        if (finish) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_RB_ZERO: state_nxt = S_RB_FAR;
      S_RB_FAR:  state_nxt = S_RB_DIV;
      S_RB_DIV:  state_nxt = S_RB_WAIT;
      S_RB_WAIT: begin
        if (stat.div_done) state_nxt = stat.rb_last ? S_IDLE : S_RB_DIV;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (func)
            FUNC_TRACE: cmd.trace_latch = 1'b1;
            FUNC_TRIG:  cmd.trig_we     = 1'b1;
            FUNC_CELL:  cmd.cell_we     = 1'b1;
            default:    ;
          endcase
        end
      end
      S_TRIG: ;
      S_INIT: cmd.march_init = 1'b1;
      S_MARCH: begin
        cmd.march_step = !stat.wall && !stat.too_low;
        cmd.res_load   = finish;
      end
      S_RESULT:  cmd.out_load = stat.out_free;
      S_RB_ZERO: begin
        cmd.rb_wr_zero = 1'b1;
        cmd.rb_init    = 1'b1;
      end
      S_RB_FAR:  cmd.rb_wr_far = 1'b1;
      S_RB_DIV:  cmd.div_start = 1'b1;
      S_RB_WAIT: cmd.rb_wr_step = stat.div_done;
      default: ;
    endcase
  end

endmodule

// ===== hdl/grm_dp.sv =====
// Datapath: wall map, step tables, distance table, ray march and result register.
module grm_dp #(
  parameter int MAX_STEPS = 32,
  parameter int MAP_BITS  = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  grm_pkg::cmd_t           cmd,
  output grm_pkg::stat_t          stat,
  input  logic [4:0]              column,
  input  logic [15:0]             pos_x,
  input  logic [15:0]             pos_y,
  input  logic [7:0]              view_angle,
  input  logic [7:0]              trig_index,
  input  logic [15:0]             sine_step,
  input  logic [15:0]             cosine_step,
  input  logic [7:0]              cell_col,
  input  logic [7:0]              cell_row,
  input  logic                    cell_wall,
  input  logic [grm_pkg::IHW-1:0] init_height,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              wall_height
);
  import grm_pkg::*;

  localparam int DW        = $clog2(MAX_STEPS);
  localparam int MAW       = 2 * MAP_BITS;
  localparam int MAP_CELLS = 1 << MAW;

  // step tables: cosine in the low half, sine in the high half
  logic [2*HW-1:0] trig_mem [0:TRIG_DEPTH-1];
  logic [2*HW-1:0] trig_rd_r;
  logic [HW-1:0]   dist_mem [0:MAX_STEPS-1];
  logic [HW-1:0]   dist_rd_r;
  logic            map_mem  [0:MAP_CELLS-1];
  logic            map_rd_r;

  logic [ANGW-1:0] ang_r;
  logic [HW-1:0]   px_r, py_r, sx_r, sy_r, x_r, y_r, h_r;
  logic [DW-1:0]   d_r;
  logic [7:0]      res_r;
  logic [7:0]      res_nxt;
  logic [MAW-1:0]  clr_addr_r;
  logic [DW-1:0]   i_r;
  logic [HW-1:0]   prev_r;
  logic            out_valid_r;
  logic [7:0]      out_data_r;

  logic [HW-1:0]   x_nxt, y_nxt, h_nxt;
  logic [MAW-1:0]  map_raddr, map_waddr;
  logic            map_wdata, map_we;
  logic [DW-1:0]   dist_raddr, dist_waddr;
  logic [HW-1:0]   dist_wdata;
  logic            dist_we;
  logic            div_done;
  logic [IHW-1:0]  quo;

  assign x_nxt = x_r + sx_r;
  assign y_nxt = y_r + sy_r;
  assign h_nxt = h_r - dist_rd_r;

  assign map_raddr = cmd.march_init ? {py_r[8 +: MAP_BITS], px_r[8 +: MAP_BITS]}
                                    : {y_nxt[8 +: MAP_BITS], x_nxt[8 +: MAP_BITS]};
  assign map_we    = cmd.clr_step || cmd.cell_we;
  assign map_waddr = cmd.clr_step ? clr_addr_r
                                  : {cell_row[MAP_BITS-1:0], cell_col[MAP_BITS-1:0]};
  assign map_wdata = cmd.clr_step ? 1'b0 : cell_wall;

  assign dist_raddr = cmd.march_init ? '0 : DW'(d_r + DW'(1));
  assign dist_we    = cmd.rb_wr_zero || cmd.rb_wr_far || cmd.rb_wr_step;

  always_comb begin
    dist_waddr = i_r;
    dist_wdata = prev_r - {1'b0, quo};
    if (cmd.rb_wr_zero) begin
      dist_waddr = '0;
      dist_wdata = '0;
    end else if (cmd.rb_wr_far) begin
      dist_waddr = DW'(MAX_STEPS - 1);
      dist_wdata = FAR_DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trig_we) trig_mem[trig_index] <= {sine_step, cosine_step};
    trig_rd_r <= trig_mem[ang_r];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rd_r <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rd_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + MAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trace_latch) begin
      ang_r <= ANGW'({3'd0, column}) + view_angle - HALF_COLS;
      px_r  <= pos_x;
      py_r  <= pos_y;
    end
    if (cmd.march_init) begin
      sx_r <= trig_rd_r[HW-1:0];
      sy_r <= trig_rd_r[2*HW-1:HW];
      x_r  <= px_r;
      y_r  <= py_r;
      h_r  <= {1'b0, init_height};
      d_r  <= '0;
    end else if (cmd.march_step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      h_r <= h_nxt;
      d_r <= d_r + DW'(1);
    end
    if (cmd.res_load) res_r <= res_nxt;
  end

  always_comb begin
    if (map_rd_r) begin
      res_nxt = h_r[15:8];
    end else if ($signed(h_r) < $signed(dist_rd_r)) begin
      res_nxt = 8'd0;
    end else begin
      res_nxt = h_nxt[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rb_init) begin
      i_r    <= DW'(1);
      prev_r <= {1'b0, init_height};
    end else if (cmd.rb_wr_step) begin
      i_r    <= i_r + DW'(1);
      prev_r <= {1'b0, quo};
    end
  end

  grm_div #(
    .DVW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (init_height),
    .divisor  (i_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= res_r;
  end

  assign stat.clr_last   = &clr_addr_r;
  assign stat.wall       = map_rd_r;
  assign stat.too_low    = $signed(h_r) < $signed(dist_rd_r);
  assign stat.march_last = d_r == DW'(MAX_STEPS - 1);
  assign stat.div_done   = div_done;
  assign stat.rb_last    = i_r == DW'(MAX_STEPS - 2);
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid  = out_valid_r;
  assign wall_height = out_data_r;

endmodule

// ===== hdl/grid_ray_march_height_unit.sv =====
// Top level of the grid ray march height unit: ports, config register, controller and datapath.
// Input stream: in_tuser carries the item kind (trace, trig write, cell write, rebuild),
// in_tdata the fields. A trace beat casts one ray from the player pose through one screen
// column over the one-bit wall map and returns one out_ beat with the wall height in pixels.
// Trig writes, cell writes and rebuilds return no beat.
// A trace holds the input (in_tready low) through a march loop of at most MAX_STEPS map steps,
// which reads one map cell and one distance entry per cycle; the height then passes through
// res_r and the output register out_data_r to out_tdata. Trig and cell writes leave the unit
// idle and ready. A rebuild forms each inner distance entry with the one-bit-per-cycle divider.
// After reset the map is swept to open, one cell a cycle, over all 2^(2*MAP_BITS) cells
// (65536 by default); in_tready stays low during the sweep, config writes are taken.
// The result sits in an output register: a stalled receiver does not block the next item,
// but a finished trace waits in res_r until the output register drains.
// Config: init_height at address 0. The user must write it only while the unit is idle;
// the unit itself does not enforce this.
module grid_ray_march_height_unit #(
  parameter int MAX_STEPS = 32,
  parameter int MAP_BITS  = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [4:0] column, [20:5] pos_x, [36:21] pos_y, [44:37] view_angle,
  // [52:45] trig_index, [68:53] sine_step, [84:69] cosine_step,
  // [92:85] cell_col, [100:93] cell_row, [101] cell_wall, [103:102] zero
  input  logic [103:0]               in_tdata,
  // [1:0] func
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [7:0] wall_height
  output logic [7:0]                 out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [grm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [grm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [grm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import grm_pkg::*;

  logic [IHW-1:0] init_height_r;
  logic           cfg_hit;
  cmd_t           cmd;
  stat_t          stat;

  assign cfg_hit    = cfg_paddr[2] == CFG_IDX_INIT_HEIGHT;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? CFG_DW'(init_height_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_height_r <= INIT_HEIGHT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      init_height_r <= cfg_pwdata[IHW-1:0];
    end
  end

  grm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  grm_dp #(
    .MAX_STEPS (MAX_STEPS),
    .MAP_BITS  (MAP_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .column       (in_tdata[4:0]),
    .pos_x        (in_tdata[20:5]),
    .pos_y        (in_tdata[36:21]),
    .view_angle   (in_tdata[44:37]),
    .trig_index   (in_tdata[52:45]),
    .sine_step    (in_tdata[68:53]),
    .cosine_step  (in_tdata[84:69]),
    .cell_col     (in_tdata[92:85]),
    .cell_row     (in_tdata[100:93]),
    .cell_wall    (in_tdata[101]),
    .init_height  (init_height_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .wall_height  (out_tdata)
  );

endmodule

// ===== hdl/grm_chk.sv =====
// Port-level checker for the grid ray march height unit, with its bind.
`include "grid_ray_march_height_unit_macros.svh"

module grm_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready
);
  import grm_pkg::*;

  logic in_beat;
  logic wr_beat;

  assign in_beat = in_tvalid && in_tready;
  assign wr_beat = in_beat && (in_tuser == FUNC_TRIG || in_tuser == FUNC_CELL);

  `GRM_ASSERT_IMP(a_sweep_after_reset, clk, rst_n, !$past(rst_n), !in_tready)
  `GRM_ASSERT_NXT(a_trace_busy, clk, rst_n, in_beat && in_tuser == FUNC_TRACE, !in_tready)
  `GRM_ASSERT_NXT(a_write_one_cycle, clk, rst_n, wr_beat, in_tready)
  `GRM_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

endmodule

bind grid_ray_march_height_unit grm_chk u_grm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the grid ray march height unit, with a built-in predictor.
module testbench;
  import grm_pkg::*;

  localparam int MAX_STEPS     = 32;
  localparam int MAP_BITS      = 8;
  localparam int IDLE_PCT      = 17;
  localparam int SETTLE_CYCLES = 700;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 7;
  localparam int PHASE_BEATS   = 100;
  localparam int LONG_HOLD     = 600;
  localparam logic [CFG_AW-1:0] ADDR_INIT_HEIGHT = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_UNUSED      = 3'd4;

  typedef struct packed {
    logic [1:0]  pad;
    logic        cell_wall;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [15:0] cosine_step;
    logic [15:0] sine_step;
    logic [7:0]  trig_index;
    logic [7:0]  view_angle;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [4:0]  column;
  } beat_fields_t;

  typedef struct {
    func_t        kind;
    beat_fields_t f;
    bit           pinned;
    logic [7:0]   pinned_h;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [103:0]        in_tdata;
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  logic [14:0]         model_init = INIT_HEIGHT_RST;
  logic [15:0]         falloff [MAX_STEPS];
  logic [15:0]         sine_tab [TRIG_DEPTH];
  logic [15:0]         cosine_tab [TRIG_DEPTH];
  bit                  wall_map [1 << (2 * MAP_BITS)];
  logic [7:0]          heights_due [$];
  plan_row_t           plan [$];
  logic                pin_valid;
  logic [7:0]          pin_height;
  beat_fields_t        seen_beat;
  logic [7:0]          due_height;
  int                  fail_count = 0;
  int                  heights_seen = 0;
  int                  beats_sent = 0;
  int                  cycle_count = 0;

  always #6 clk = ~clk;

  grid_ray_march_height_unit #(
    .MAX_STEPS(MAX_STEPS),
    .MAP_BITS (MAP_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  function automatic logic [7:0] cast_ray(logic [4:0] col, logic [15:0] px, logic [15:0] py,
                                          logic [7:0] pang);
    logic [7:0]            ang;
    logic [15:0]           h, x, y, sx, sy, dlt;
    logic [2*MAP_BITS-1:0] map_idx;
    logic                  live, hit;
    int                    d;
    ang  = 8'(col) + pang - HALF_COLS;
    h    = 16'(model_init);
    x    = px;
    y    = py;
    sx   = cosine_tab[ang];
    sy   = sine_tab[ang];
    live = 1'b1;
    hit  = 1'b0;
    d    = 0;
    while (live && !hit && d < MAX_STEPS) begin
      map_idx = {y[8 +: MAP_BITS], x[8 +: MAP_BITS]};
      if (wall_map[map_idx]) begin
        hit = 1'b1;
      end else begin
        dlt = falloff[d];
        if ($signed(h) < $signed(dlt)) begin
          live = 1'b0;
        end else begin
          h = h - dlt;
          x = x + sx;
          y = y + sy;
          d++;
        end
      end
    end
    return live ? h[15:8] : 8'd0;
  endfunction

  function automatic void rebuild_falloff();
    logic [15:0] prev, h;
    int          i;
    prev = 16'(model_init);
    for (i = 1; i < MAX_STEPS - 1; i++) begin
      h          = 16'(model_init) / 16'(i);
      falloff[i] = prev - h;
      prev       = h;
    end
    falloff[0]           = '0;
    falloff[MAX_STEPS-1] = FAR_DELTA;
  endfunction

  function automatic beat_fields_t noise_beat();
    logic [127:0] r;
    beat_fields_t f;
    r     = {$urandom, $urandom, $urandom, $urandom};
    f     = r[103:0];
    f.pad = '0;
    return f;
  endfunction

  function automatic beat_fields_t trace_beat(logic [4:0] col, logic [15:0] px, logic [15:0] py,
                                              logic [7:0] ang);
    beat_fields_t f;
    f            = noise_beat();
    f.column     = col;
    f.pos_x      = px;
    f.pos_y      = py;
    f.view_angle = ang;
    return f;
  endfunction

  function automatic beat_fields_t trig_beat(logic [7:0] idx, logic [15:0] s, logic [15:0] c);
    beat_fields_t f;
    f             = noise_beat();
    f.trig_index  = idx;
    f.sine_step   = s;
    f.cosine_step = c;
    return f;
  endfunction

  function automatic beat_fields_t cell_beat(logic [7:0] col, logic [7:0] row, logic wall);
    beat_fields_t f;
    f           = noise_beat();
    f.cell_col  = col;
    f.cell_row  = row;
    f.cell_wall = wall;
    return f;
  endfunction

  function automatic logic [15:0] gentle_step();
    int v;
    v = $urandom_range(768);
    return 16'(v - 384);
  endfunction

  function automatic void plan_add(func_t kind, beat_fields_t f, bit pinned, logic [7:0] h);
    plan_row_t r;
    r.kind     = kind;
    r.f        = f;
    r.pinned   = pinned;
    r.pinned_h = h;
    plan.push_back(r);
  endfunction

  task automatic offer_beat(func_t kind, beat_fields_t f, bit pinned, logic [7:0] h);
    if (!(beats_sent >= 500 && beats_sent < 650)) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= kind;
    in_tdata   <= f;
    pin_valid  <= pinned;
    pin_height <= h;
    do @(posedge clk); while (in_tready !== 1'b1);
    beats_sent++;
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    if (wr && addr == ADDR_INIT_HEIGHT) model_init = wdata[14:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (heights_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_tvalid === 1'b1 && in_tready === 1'b1) begin
      seen_beat = in_tdata;
      case (in_tuser)
        FUNC_TRACE:
          heights_due.push_back(pin_valid ? pin_height :
                                cast_ray(seen_beat.column, seen_beat.pos_x,
                                         seen_beat.pos_y, seen_beat.view_angle));
        FUNC_TRIG: begin
          sine_tab[seen_beat.trig_index]   = seen_beat.sine_step;
          cosine_tab[seen_beat.trig_index] = seen_beat.cosine_step;
        end
        FUNC_CELL:
          wall_map[{seen_beat.cell_row[MAP_BITS-1:0], seen_beat.cell_col[MAP_BITS-1:0]}] =
            seen_beat.cell_wall;
        default:
          rebuild_falloff();
      endcase
    end
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      heights_seen++;
      if (heights_due.size() == 0) begin
        $error("wall_height: expected none, got %0d", out_tdata);
        fail_count++;
      end else begin
        due_height = heights_due.pop_front();
        if (out_tdata !== due_height) begin
          $error("wall_height: expected %0d, got %0d", due_height, out_tdata);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : sink
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && heights_seen >= 250) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (heights_seen >= 300 && heights_seen < 400) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DW-1:0] rd;
    logic [14:0]       ih;
    logic [7:0]        bx, by;
    int                ph, k, pick;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= FUNC_TRACE;
    pin_valid   <= 1'b0;
    pin_height  <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_access(1'b0, ADDR_INIT_HEIGHT, '0, rd);
    if (rd !== CFG_DW'(INIT_HEIGHT_RST)) begin
      $error("init_height: expected %0d, got %0d", INIT_HEIGHT_RST, rd);
      fail_count++;
    end

    for (k = 0; k < TRIG_DEPTH; k++)
      offer_beat(FUNC_TRIG, trig_beat(8'(k), gentle_step(), gentle_step()), 1'b0, '0);

    // start in a wall gives init_height>>8, an open ray with no motion runs out to 0
    plan_add(FUNC_REBUILD, noise_beat(), 1'b0, '0);
    plan_add(FUNC_TRIG, trig_beat(8'd0, 16'h0000, 16'h0000), 1'b0, '0);
    plan_add(FUNC_TRIG, trig_beat(8'd255, 16'h7fff, 16'h8000), 1'b0, '0);
    plan_add(FUNC_TRIG, trig_beat(8'd1, 16'h0000, 16'h0100), 1'b0, '0);
    plan_add(FUNC_TRIG, trig_beat(8'd2, 16'hff00, 16'h0000), 1'b0, '0);
    plan_add(FUNC_CELL, cell_beat(8'd0, 8'd0, 1'b1), 1'b0, '0);
    plan_add(FUNC_CELL, cell_beat(8'd255, 8'd255, 1'b1), 1'b0, '0);
    plan_add(FUNC_CELL, cell_beat(8'd3, 8'd2, 1'b1), 1'b0, '0);
    plan_add(FUNC_TRACE, trace_beat(5'd16, 16'h0080, 16'h0080, 8'd0), 1'b1, 8'd64);
    plan_add(FUNC_TRACE, trace_beat(5'd16, 16'h0580, 16'h0580, 8'd0), 1'b1, 8'd0);
    plan_add(FUNC_TRACE, trace_beat(5'd0, 16'hff80, 16'hff80, 8'd15), 1'b1, 8'd64);
    plan_add(FUNC_TRACE, trace_beat(5'd17, 16'h0180, 16'h0280, 8'd0), 1'b1, 8'd64);
    plan_add(FUNC_TRACE, trace_beat(5'd17, 16'hfe80, 16'h0280, 8'd0), 1'b0, '0);
    plan_add(FUNC_TRACE, trace_beat(5'd18, 16'h0380, 16'h0580, 8'd0), 1'b0, '0);
    plan_add(FUNC_TRACE, trace_beat(5'd0, 16'h7fff, 16'h8000, 8'd15), 1'b0, '0);
    plan_add(FUNC_TRACE, trace_beat(5'd31, 16'h8000, 16'h7fff, 8'd255), 1'b0, '0);
    plan_add(FUNC_CELL, cell_beat(8'd0, 8'd0, 1'b0), 1'b0, '0);
    plan_add(FUNC_TRACE, trace_beat(5'd16, 16'h0080, 16'h0080, 8'd0), 1'b1, 8'd0);
    plan_add(FUNC_TRACE, trace_beat(5'd31, 16'h0000, 16'hffff, 8'd0), 1'b0, '0);
    plan_add(FUNC_REBUILD, noise_beat(), 1'b0, '0);
    foreach (plan[i])
      offer_beat(plan[i].kind, plan[i].f, plan[i].pinned, plan[i].pinned_h);

    for (ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph)
        0:       ih = 15'd1;
        1:       ih = 15'h7fff;
        2:       ih = INIT_HEIGHT_RST;
        default: ih = 15'($urandom_range(32767, 1));
      endcase
      cfg_access(1'b1, ADDR_INIT_HEIGHT, {17'($urandom), ih}, rd);
      cfg_access(1'b1, ADDR_UNUSED, $urandom, rd);
      cfg_access(1'b0, ADDR_INIT_HEIGHT, '0, rd);
      if (rd !== {17'd0, model_init}) begin
        $error("init_height: expected %0d, got %0d", model_init, rd);
        fail_count++;
      end
      // keep the stale falloff table for one phase
      if (ph != 4) offer_beat(FUNC_REBUILD, noise_beat(), 1'b0, '0);

      bx = 8'($urandom);
      by = 8'($urandom);
      repeat (20)
        offer_beat(FUNC_CELL, cell_beat(bx + 8'($urandom_range(15)),
                                        by + 8'($urandom_range(15)), 1'b1), 1'b0, '0);
      for (k = 0; k < PHASE_BEATS; k++) begin
        pick = $urandom_range(99);
        if (pick < 62)
          offer_beat(FUNC_TRACE,
                     trace_beat(5'($urandom),
                                {bx + 8'($urandom_range(15)), 8'($urandom)},
                                {by + 8'($urandom_range(15)), 8'($urandom)},
                                8'($urandom)), 1'b0, '0);
        else if (pick < 72)
          offer_beat(FUNC_TRACE, noise_beat(), 1'b0, '0);
        else if (pick < 84)
          offer_beat(FUNC_CELL, cell_beat(bx + 8'($urandom_range(15)),
                                          by + 8'($urandom_range(15)), 1'($urandom)), 1'b0, '0);
        else if (pick < 88)
          offer_beat(FUNC_CELL, noise_beat(), 1'b0, '0);
        else if (pick < 96)
          offer_beat(FUNC_TRIG,
                     ($urandom_range(9) == 0) ? noise_beat() :
                     trig_beat(8'($urandom), gentle_step(), gentle_step()), 1'b0, '0);
        else
          offer_beat(FUNC_REBUILD, noise_beat(), 1'b0, '0);
      end
    end

    quiesce();
    if (fail_count == 0 && heights_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/grm_pkg.sv
hdl/grm_div.sv
hdl/grm_ctrl.sv
hdl/grm_dp.sv
hdl/grid_ray_march_height_unit.sv
hdl/grm_chk.sv
dv/testbench.sv
